FILE: hdl/tsc_pkg.sv
// tsc_pkg: shared types, byte codes and sizes for the template-to-script converter
`timescale 1ns / 1ps
package tsc_pkg;

   localparam int WIN_DEPTH = 5;   // marker lookahead window
   localparam int SEQ_DEPTH = 6;   // most bytes one step of the datapath can produce
   localparam int WIN_CNT_W = $clog2(WIN_DEPTH + 1);
   localparam int SEQ_CNT_W = $clog2(SEQ_DEPTH + 1);
   localparam int SEQ_IDX_W = $clog2(SEQ_DEPTH);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QM    = 8'h3F;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_V     = 8'h76;
   localparam logic [7:0] CH_LBR   = 8'h7B;
   localparam logic [7:0] CH_RBR   = 8'h7D;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // latch the request
      logic sep;        // load the line separator, update line flags
      logic append;     // push the request byte into the window
      logic front;      // handle the token at the window front, load its bytes
      logic flush_end;  // empty the window, apply the line-end / NUL flags
      logic close;      // load the bytes that close an open text call
      logic emit;       // move the next loaded byte toward the output
      logic finish;     // release the held byte as the last of the request
      logic clear;      // return the converter state to its reset value
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_nl;
      logic is_nul;
      logic skip;
      logic last;
      logic win_full;
      logic flush_more;
      logic seq_done;
      logic emit_ok;
      logic fin_ok;
   } status_type;

endpackage

FILE: hdl/template_to_script_converter.sv
// template_to_script_converter: top level joining the controller and the datapath
`timescale 1ns / 1ps
// Converts a template file, one byte per request, into script text, one byte per
// response; run_end marks the last response byte caused by a request, and a request
// may cause none. Plain text is wrapped in vp("..."), <?lua ... ?> is copied as code
// and {{! ... !}} becomes vp( ... ). Markers are found through a five-byte lookahead
// window, so text appears up to four requests late, until a line end, a NUL or the
// final byte flushes it. One request is handled at a time by a sequencer: an ordinary
// byte is pushed into the window unless its line is being skipped, a full window then
// gives up one token, a line end or NUL hands out the tokens left in the window one by
// one, the final byte does the same and then closes any open text call, and a stalled
// response holds the sequencer until it drains.
// The response register lets the next request in while the last response is waiting.
module template_to_script_converter
   import tsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   tsc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/tsc_datapath.sv
// tsc_datapath: mode flags, lookahead window, token decode and output staging
`timescale 1ns / 1ps
module tsc_datapath
   import tsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic                 in_code_ff, in_code_in;
   logic                 in_print_ff, in_print_in;
   logic                 call_open_ff, call_open_in;
   logic                 seen_line_ff, seen_line_in;
   logic                 line_start_ff, line_start_in;
   logic                 skip_line_ff, skip_line_in;
   logic [7:0]           win_ff [WIN_DEPTH];
   logic [7:0]           win_in [WIN_DEPTH];
   logic [WIN_CNT_W-1:0] win_cnt_ff, win_cnt_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic [7:0]           seq_ff [SEQ_DEPTH];
   logic [7:0]           seq_in [SEQ_DEPTH];
   logic [SEQ_CNT_W-1:0] seq_len_ff, seq_len_in;
   logic [SEQ_CNT_W-1:0] seq_idx_ff, seq_idx_in;
   logic [7:0]           pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // token decode at the window front
   logic [7:0]           f_buf [SEQ_DEPTH];
   logic [SEQ_CNT_W-1:0] f_len;
   logic                 f_code, f_print, f_call, f_discard;
   logic [WIN_CNT_W-1:0] f_k;
   logic                 m_copen, m_popen, m_pclose, m_cclose;
   logic                 out_free;

   always_comb begin
      m_copen  = (win_cnt_ff == WIN_CNT_W'(WIN_DEPTH)) && win_ff[0] == CH_LT &&
                 win_ff[1] == CH_QM && win_ff[2] == CH_L && win_ff[3] == CH_U &&
                 win_ff[4] == CH_A;
      m_popen  = !in_code_ff && !in_print_ff && (win_cnt_ff >= WIN_CNT_W'(4)) &&
                 win_ff[0] == CH_LBR && win_ff[1] == CH_LBR && win_ff[2] == CH_BANG &&
                 win_ff[3] == CH_SPACE;
      m_pclose = !in_code_ff && in_print_ff && (win_cnt_ff >= WIN_CNT_W'(4)) &&
                 win_ff[0] == CH_SPACE && win_ff[1] == CH_BANG && win_ff[2] == CH_RBR &&
                 win_ff[3] == CH_RBR;
      m_cclose = (win_cnt_ff >= WIN_CNT_W'(2)) && win_ff[0] == CH_QM && win_ff[1] == CH_GT;

      for (int i = 0; i < SEQ_DEPTH; i++) begin
         f_buf[i] = CH_NUL;
      end
      f_len     = '0;
      f_code    = in_code_ff;
      f_print   = in_print_ff;
      f_call    = call_open_ff;
      f_discard = 1'b0;
      f_k       = '0;

      if (m_copen) begin
         if (in_code_ff) begin
            f_discard = 1'b1;
         end else begin
            f_code = 1'b1;
            if (call_open_ff) begin
               f_buf[0] = CH_QUOTE;
               f_buf[1] = CH_RPAR;
               f_buf[2] = CH_LF;
               f_len    = SEQ_CNT_W'(3);
               f_call   = 1'b0;
            end
            f_k = WIN_CNT_W'(5);
         end
      end else if (m_popen) begin
         if (call_open_ff) begin
            f_buf[f_len[SEQ_IDX_W-1:0]] = CH_QUOTE;
            f_len = f_len + 1'b1;
            f_buf[f_len[SEQ_IDX_W-1:0]] = CH_RPAR;
            f_len = f_len + 1'b1;
            f_buf[f_len[SEQ_IDX_W-1:0]] = CH_LF;
            f_len = f_len + 1'b1;
            f_call = 1'b0;
         end
         f_buf[f_len[SEQ_IDX_W-1:0]] = CH_V;
         f_len = f_len + 1'b1;
         f_buf[f_len[SEQ_IDX_W-1:0]] = CH_P;
         f_len = f_len + 1'b1;
         f_buf[f_len[SEQ_IDX_W-1:0]] = CH_LPAR;
         f_len = f_len + 1'b1;
         f_print = 1'b1;
         f_k     = WIN_CNT_W'(4);
      end else if (m_pclose) begin
         f_print  = 1'b0;
         f_buf[0] = CH_RPAR;
         f_buf[1] = CH_LF;
         f_len    = SEQ_CNT_W'(2);
         f_k      = WIN_CNT_W'(4);
      end else if (m_cclose) begin
         if (!in_code_ff) begin
            f_discard = 1'b1;
         end else begin
            f_code = 1'b0;
            f_k    = WIN_CNT_W'(2);
         end
      end else begin
         if (in_code_ff || in_print_ff) begin
            f_buf[0] = win_ff[0];
            f_len    = SEQ_CNT_W'(1);
         end else begin
            if (!call_open_ff) begin
               f_buf[0] = CH_V;
               f_buf[1] = CH_P;
               f_buf[2] = CH_LPAR;
               f_buf[3] = CH_QUOTE;
               f_len    = SEQ_CNT_W'(4);
               f_call   = 1'b1;
            end
            if (win_ff[0] == CH_QUOTE) begin
               f_buf[f_len[SEQ_IDX_W-1:0]] = CH_BSL;
               f_len = f_len + 1'b1;
            end
            if (win_ff[0] != CH_LF && win_ff[0] != CH_CR) begin
               f_buf[f_len[SEQ_IDX_W-1:0]] = win_ff[0];
               f_len = f_len + 1'b1;
            end
         end
         f_k = WIN_CNT_W'(1);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic [WIN_CNT_W:0] src;

      src           = '0;
      in_code_in    = in_code_ff;
      in_print_in   = in_print_ff;
      call_open_in  = call_open_ff;
      seen_line_in  = seen_line_ff;
      line_start_in = line_start_ff;
      skip_line_in  = skip_line_ff;
      win_cnt_in    = win_cnt_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      seq_len_in    = seq_len_ff;
      seq_idx_in    = seq_idx_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_in[i] = win_ff[i];
      end
      for (int i = 0; i < SEQ_DEPTH; i++) begin
         seq_in[i] = seq_ff[i];
      end

      if (cmd.accept) begin
         byte_in = req_data.in_byte;
         last_in = req_data.last;
      end

      if (cmd.sep) begin
         seq_len_in = '0;
         seq_idx_in = '0;
         if (line_start_ff) begin
            if (seen_line_ff) begin
               if (call_open_ff) begin
                  seq_in[0]  = CH_BSL;
                  seq_in[1]  = CH_N;
                  seq_len_in = SEQ_CNT_W'(2);
               end else begin
                  seq_in[0]  = CH_LF;
                  seq_len_in = SEQ_CNT_W'(1);
               end
            end
            line_start_in = 1'b0;
            seen_line_in  = 1'b1;
         end
      end

      if (cmd.append) begin
         win_in[win_cnt_ff[WIN_CNT_W-1:0]] = byte_ff;
         win_cnt_in = win_cnt_ff + 1'b1;
      end

      if (cmd.front) begin
         for (int i = 0; i < SEQ_DEPTH; i++) begin
            seq_in[i] = f_buf[i];
         end
         seq_len_in   = f_len;
         seq_idx_in   = '0;
         in_code_in   = f_code;
         in_print_in  = f_print;
         call_open_in = f_call;
         if (f_discard) begin
            win_cnt_in   = '0;
            skip_line_in = 1'b1;
         end else begin
            // slide the window down by the consumed length
            for (int i = 0; i < WIN_DEPTH; i++) begin
               src = (WIN_CNT_W + 1)'(i) + {1'b0, f_k};
               if (src < (WIN_CNT_W + 1)'(WIN_DEPTH)) begin
                  win_in[i] = win_ff[src[WIN_CNT_W-1:0]];
               end
            end
            win_cnt_in = win_cnt_ff - f_k;
         end
      end

      if (cmd.flush_end) begin
         win_cnt_in = '0;
         if (byte_ff == CH_LF) begin
            skip_line_in  = 1'b0;
            line_start_in = 1'b1;
         end else if (byte_ff == CH_NUL) begin
            skip_line_in = 1'b1;
         end
      end

      if (cmd.close) begin
         seq_len_in = '0;
         seq_idx_in = '0;
         if (call_open_ff) begin
            seq_in[0]    = CH_QUOTE;
            seq_in[1]    = CH_RPAR;
            seq_in[2]    = CH_LF;
            seq_len_in   = SEQ_CNT_W'(3);
            call_open_in = 1'b0;
         end
      end

      // one held byte so that the last byte of a request can be flagged
      if (cmd.emit) begin
         if (pend_valid_ff) begin
            rsp_in       = '{out_byte: pend_ff, run_end: 1'b0};
            rsp_valid_in = 1'b1;
         end
         pend_in       = seq_ff[seq_idx_ff[SEQ_IDX_W-1:0]];
         pend_valid_in = 1'b1;
         seq_idx_in    = seq_idx_ff + 1'b1;
      end

      if (cmd.finish && pend_valid_ff) begin
         rsp_in        = '{out_byte: pend_ff, run_end: 1'b1};
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end

      if (cmd.clear) begin
         in_code_in    = 1'b0;
         in_print_in   = 1'b0;
         call_open_in  = 1'b0;
         seen_line_in  = 1'b0;
         line_start_in = 1'b1;
         skip_line_in  = 1'b0;
         win_cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_code_ff    <= 1'b0;
         in_print_ff   <= 1'b0;
         call_open_ff  <= 1'b0;
         seen_line_ff  <= 1'b0;
         line_start_ff <= 1'b1;
         skip_line_ff  <= 1'b0;
         win_cnt_ff    <= '0;
         seq_len_ff    <= '0;
         seq_idx_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_code_ff    <= in_code_in;
         in_print_ff   <= in_print_in;
         call_open_ff  <= call_open_in;
         seen_line_ff  <= seen_line_in;
         line_start_ff <= line_start_in;
         skip_line_ff  <= skip_line_in;
         win_cnt_ff    <= win_cnt_in;
         seq_len_ff    <= seq_len_in;
         seq_idx_ff    <= seq_idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_ff[i] <= win_in[i];
      end
      for (int i = 0; i < SEQ_DEPTH; i++) begin
         seq_ff[i] <= seq_in[i];
      end
   end

   always_comb begin
      status.is_nl      = (byte_ff == CH_LF);
      status.is_nul     = (byte_ff == CH_NUL);
      status.skip       = skip_line_ff;
      status.last       = last_ff;
      status.win_full   = (win_cnt_ff == WIN_CNT_W'(WIN_DEPTH));
      status.flush_more = (win_cnt_ff != '0) && !skip_line_ff;
      status.seq_done   = (seq_idx_ff == seq_len_ff);
      status.emit_ok    = !pend_valid_ff || out_free;
      status.fin_ok     = !pend_valid_ff || out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/tsc_controller.sv
// tsc_controller: state machine that sequences one request through the datapath
`timescale 1ns / 1ps
module tsc_controller
   import tsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SEP     = 4'd1;
   localparam logic [3:0] S_BYTE    = 4'd2;
   localparam logic [3:0] S_APCHK   = 4'd3;
   localparam logic [3:0] S_FLUSH   = 4'd4;
   localparam logic [3:0] S_FIN_CHK = 4'd5;
   localparam logic [3:0] S_CLOSE   = 4'd6;
   localparam logic [3:0] S_EMIT    = 4'd7;
   localparam logic [3:0] S_DONE    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [3:0] ret_ff, ret_in;
   logic       fin_phase_ff, fin_phase_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fin_phase_in = fin_phase_ff;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept   = 1'b1;
               fin_phase_in = 1'b0;
               state_in     = S_SEP;
            end
         end
         S_SEP: begin
            cmd.sep  = 1'b1;
            ret_in   = S_BYTE;
            state_in = S_EMIT;
         end
         S_BYTE: begin
            if (status.is_nl) begin
               state_in = S_FLUSH;
            end else if (status.skip) begin
               state_in = S_FIN_CHK;
            end else if (status.is_nul) begin
               state_in = S_FLUSH;
            end else begin
               cmd.append = 1'b1;
               state_in   = S_APCHK;
            end
         end
         S_APCHK: begin
            // a full window gives up exactly one token
            if (status.win_full) begin
               cmd.front = 1'b1;
               ret_in    = S_FIN_CHK;
               state_in  = S_EMIT;
            end else begin
               state_in = S_FIN_CHK;
            end
         end
         S_FLUSH: begin
            if (status.flush_more) begin
               cmd.front = 1'b1;
               ret_in    = S_FLUSH;
               state_in  = S_EMIT;
            end else begin
               cmd.flush_end = 1'b1;
               state_in      = fin_phase_ff ? S_CLOSE : S_FIN_CHK;
            end
         end
         S_FIN_CHK: begin
            if (status.last) begin
               fin_phase_in = 1'b1;
               state_in     = S_FLUSH;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CLOSE: begin
            cmd.close = 1'b1;
            ret_in    = S_DONE;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (status.seq_done) begin
               state_in = ret_ff;
            end else if (status.emit_ok) begin
               cmd.emit = 1'b1;
            end
         end
         S_DONE: begin
            if (status.fin_ok) begin
               cmd.finish = 1'b1;
               cmd.clear  = fin_phase_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         fin_phase_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fin_phase_ff <= fin_phase_in;
      end
   end

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for the template-to-script converter
`timescale 1ns / 1ps
module testbench;
   import tsc_pkg::*;

   localparam int MAX_OUT      = 32;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_BYTES = 225;
   localparam int TOTAL_BYTES  = 270;

   // markers packed first byte high, short ones padded at the low end
   localparam logic [39:0] MK_CODE_OPEN   = {CH_LT, CH_QM, CH_L, CH_U, CH_A};
   localparam logic [39:0] MK_PRINT_OPEN  = {CH_LBR, CH_LBR, CH_BANG, CH_SPACE, 8'h00};
   localparam logic [39:0] MK_PRINT_CLOSE = {CH_SPACE, CH_BANG, CH_RBR, CH_RBR, 8'h00};
   localparam logic [39:0] MK_CODE_CLOSE  = {CH_QM, CH_GT, 24'h000000};

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // converter state as the bench sees it
   logic       sc_code, sc_print, sc_call, sc_seen, sc_line_start, sc_skip;
   logic [7:0] pend [WIN_DEPTH];
   int         pend_cnt;
   logic [7:0] step_bytes [MAX_OUT];
   int         step_cnt;
   rsp_type    expected_script [$];

   logic steady = 1'b0;
   int   errors = 0;
   int   bytes_sent = 0;
   int   bytes_checked = 0;
   int   files_done = 0;
   int   stall_cycles = 0;

   template_to_script_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic void clear_state();
      sc_code       = 1'b0;
      sc_print      = 1'b0;
      sc_call       = 1'b0;
      sc_seen       = 1'b0;
      sc_line_start = 1'b1;
      sc_skip       = 1'b0;
      pend_cnt      = 0;
   endfunction

   function automatic void put_char(logic [7:0] c);
      if (step_cnt < MAX_OUT) begin
         step_bytes[step_cnt] = c;
         step_cnt++;
      end
   endfunction

   function automatic void close_text_call();
      if (sc_call) begin
         put_char(CH_QUOTE);
         put_char(CH_RPAR);
         put_char(CH_LF);
         sc_call = 1'b0;
      end
   endfunction

   function automatic bit pend_starts_with(logic [39:0] mk, int len);
      if (pend_cnt < len)
         return 1'b0;
      for (int i = 0; i < len; i++)
         if (pend[i] != mk[39 - 8*i -: 8])
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic void drop_pend(int k);
      if (k >= pend_cnt) begin
         pend_cnt = 0;
      end else begin
         for (int i = 0; i < pend_cnt - k; i++)
            pend[i] = pend[i + k];
         pend_cnt -= k;
      end
   endfunction

   function automatic void discard_rest();
      pend_cnt = 0;
      sc_skip  = 1'b1;
   endfunction

   // one token off the front of the lookahead window
   function automatic void handle_front();
      logic [7:0] c;
      if (pend_starts_with(MK_CODE_OPEN, 5)) begin
         if (sc_code) begin
            discard_rest();
         end else begin
            sc_code = 1'b1;
            close_text_call();
            drop_pend(5);
         end
      end else if (!sc_code && !sc_print && pend_starts_with(MK_PRINT_OPEN, 4)) begin
         close_text_call();
         put_char(CH_V);
         put_char(CH_P);
         put_char(CH_LPAR);
         sc_print = 1'b1;
         drop_pend(4);
      end else if (!sc_code && sc_print && pend_starts_with(MK_PRINT_CLOSE, 4)) begin
         sc_print = 1'b0;
         put_char(CH_RPAR);
         put_char(CH_LF);
         drop_pend(4);
      end else if (pend_starts_with(MK_CODE_CLOSE, 2)) begin
         if (!sc_code) begin
            discard_rest();
         end else begin
            sc_code = 1'b0;
            drop_pend(2);
         end
      end else begin
         c = pend[0];
         if (sc_code || sc_print) begin
            put_char(c);
         end else begin
            if (!sc_call) begin
               put_char(CH_V);
               put_char(CH_P);
               put_char(CH_LPAR);
               put_char(CH_QUOTE);
               sc_call = 1'b1;
            end
            if (c == CH_QUOTE)
               put_char(CH_BSL);
            if (c != CH_LF && c != CH_CR)
               put_char(c);
         end
         drop_pend(1);
      end
   endfunction

   function automatic void flush_pend();
      while (pend_cnt > 0 && !sc_skip)
         handle_front();
      pend_cnt = 0;
   endfunction

   // script bytes caused by one template byte, queued for the checker
   function automatic void predict_script(logic [7:0] b, logic fin);
      rsp_type r;
      step_cnt = 0;
      if (sc_line_start) begin
         if (sc_seen) begin
            if (sc_call) begin
               put_char(CH_BSL);
               put_char(CH_N);
            end else begin
               put_char(CH_LF);
            end
         end
         sc_line_start = 1'b0;
         sc_seen       = 1'b1;
      end
      if (b == CH_LF) begin
         flush_pend();
         sc_skip       = 1'b0;
         sc_line_start = 1'b1;
      end else if (!sc_skip) begin
         if (b == CH_NUL) begin
            flush_pend();
            sc_skip = 1'b1;
         end else begin
            if (pend_cnt < WIN_DEPTH) begin
               pend[pend_cnt] = b;
               pend_cnt++;
            end
            while (pend_cnt >= WIN_DEPTH && !sc_skip)
               handle_front();
         end
      end
      if (fin) begin
         flush_pend();
         close_text_call();
         clear_state();
      end
      for (int i = 0; i < step_cnt; i++) begin
         r.out_byte = step_bytes[i];
         r.run_end  = (i == step_cnt - 1);
         expected_script.insert(expected_script.size(), r);
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fin);
      req_type item;
      item.in_byte = b;
      item.last    = fin;
      @(negedge clock);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_script(b, fin);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input logic end_file);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], end_file && (i == s.len() - 1));
   endtask

   task automatic send_words(input int n);
      repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
   endtask

   task automatic test_text_escapes();
      send_byte(CH_QUOTE, 1'b0);
      send_byte(CH_CR, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_NUL, 1'b0);
      send_byte(CH_A, 1'b0);     // dropped, line is being skipped
      send_byte(CH_LF, 1'b0);
   endtask

   task automatic test_code_section();
      send_text("<?lua?>", 1'b0);
      send_byte(CH_LF, 1'b0);
   endtask

   task automatic test_stray_code_close();
      send_text("?>", 1'b0);
      send_byte(CH_LF, 1'b0);
   endtask

   task automatic test_print_section();
      send_text("{{!  !}}", 1'b1);
      files_done++;
   endtask

   task automatic test_file_end();
      send_text("z\n", 1'b1);
      files_done++;
   endtask

   task automatic send_fragment();
      int kind;
      kind = $urandom_range(0, 19);
      case (kind) inside
         [0:3]: send_words($urandom_range(1, 6));
         4: send_byte(CH_QUOTE, 1'b0);
         5: begin
            send_byte(CH_CR, 1'b0);
            send_byte(CH_LF, 1'b0);
         end
         [6:7]: send_byte(CH_LF, 1'b0);
         [8:10]: begin
            send_text("<?lua", 1'b0);
            send_words($urandom_range(0, 5));
            if ($urandom_range(0, 2) == 0)
               send_byte(CH_LF, 1'b0);
            send_text("?>", 1'b0);
         end
         [11:12]: begin
            send_text("{{! ", 1'b0);
            send_words($urandom_range(0, 5));
            send_text(" !}}", 1'b0);
         end
         13: send_text("?>", 1'b0);
         14: send_text("<?lua<?lua", 1'b0);   // second opener lands inside code
         15: send_byte(CH_NUL, 1'b0);
         16: send_text(($urandom_range(0, 1) == 0) ? "{{!" : "<?l", 1'b0);
         default: send_byte(8'($urandom_range(0, 255)), 1'b0);
      endcase
   endtask

   task automatic send_random_files(input int upto);
      while (bytes_sent < upto) begin
         repeat ($urandom_range(2, 10)) send_fragment();
         if ($urandom_range(0, 3) == 0)
            send_byte(CH_LF, 1'b1);
         else
            send_byte(8'($urandom_range(0, 255)), 1'b1);
         files_done++;
      end
   endtask

   task automatic test_random_templates();
      send_random_files(RANDOM_BYTES);
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      send_random_files(TOTAL_BYTES);
   endtask

   // response side stalls in random bursts
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!steady && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_script
      rsp_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (rsp_valid && rsp_ready) begin
            if (expected_script.size() == 0) begin
               $display("%0t: unexpected script byte %h run_end %b",
                        $time, rsp_data.out_byte, rsp_data.run_end);
               errors++;
            end else begin
               want = expected_script.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %h got %h",
                           $time, want.out_byte, rsp_data.out_byte);
                  errors++;
               end
               if (rsp_data.run_end !== want.run_end) begin
                  $display("%0t: run_end expected %b got %b",
                           $time, want.run_end, rsp_data.run_end);
                  errors++;
               end
               bytes_checked++;
            end
         end
         if (stall_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles, %0d bytes pending",
                     $time, IDLE_LIMIT, expected_script.size());
            $display("** template_to_script_converter: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      clear_state();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_text_escapes();
      test_code_section();
      test_stray_code_close();
      test_print_section();
      test_file_end();
      test_random_templates();
      test_steady_stream();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_script.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("fed %0d template bytes in %0d files, checked %0d script bytes",
               bytes_sent, files_done, bytes_checked);
      $display("covered quotes, CR, NUL, code and print sections, stray markers, file ends");
      if (errors == 0) begin
         $display("** template_to_script_converter: PASSED **");
      end else begin
         $display("%0d mismatches", errors);
         $display("** template_to_script_converter: FAILED **");
      end
      $finish;
   end

endmodule

FILE: template_to_script_converter.f
hdl/tsc_pkg.sv
hdl/tsc_datapath.sv
hdl/tsc_controller.sv
hdl/template_to_script_converter.sv
sim/testbench.sv
